// ----- rtl/cle_pkg.sv -----
// Shared types and constants for the 8-bit load-group executor.
// Used by the decoder, the register state, the result queue, the top level
// and the port checker.
`default_nettype none

package cle_pkg;

  // Main register file slots
  localparam logic [2:0] REG_B = 3'd0;
  localparam logic [2:0] REG_C = 3'd1;
  localparam logic [2:0] REG_D = 3'd2;
  localparam logic [2:0] REG_E = 3'd3;
  localparam logic [2:0] REG_H = 3'd4;
  localparam logic [2:0] REG_L = 3'd5;
  localparam logic [2:0] REG_F = 3'd6;
  localparam logic [2:0] REG_A = 3'd7;

  // Memory operand code in the register fields
  localparam logic [2:0] OPND_MEM = 3'd6;

  // Input item function
  localparam logic FUNC_INSTR = 1'b0;
  localparam logic FUNC_REPLY = 1'b1;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_READ    = 2'd0,
    KIND_WRITE   = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_t;

  // Opcodes
  localparam logic [7:0] OP_HALT     = 8'h76;
  localparam logic [7:0] OP_LD_A_BC  = 8'h0A;
  localparam logic [7:0] OP_LD_A_DE  = 8'h1A;
  localparam logic [7:0] OP_LD_BC_A  = 8'h02;
  localparam logic [7:0] OP_LD_DE_A  = 8'h12;
  localparam logic [7:0] OP_LD_A_NN  = 8'h3A;
  localparam logic [7:0] OP_LD_NN_A  = 8'h32;
  localparam logic [7:0] OP_PFX_ED   = 8'hED;
  localparam logic [7:0] OP_PFX_DD   = 8'hDD;
  localparam logic [7:0] OP_PFX_FD   = 8'hFD;
  localparam logic [7:0] ED_LD_A_I   = 8'h57;
  localparam logic [7:0] ED_LD_I_A   = 8'h47;
  localparam logic [7:0] ED_LD_A_R   = 8'h5F;
  localparam logic [7:0] ED_LD_R_A   = 8'h4F;
  localparam logic [7:0] IX_LD_MEM_N = 8'h36;
  localparam logic [7:0] IX_LD_LO_N  = 8'h2E;
  localparam logic [7:0] IX_LD_HI_N  = 8'h26;

  // Flags cleared by LD A,I and LD A,R: S Z H PV N
  localparam logic [7:0] FLAG_SPECIAL_MASK = 8'hD6;

  // T-state counts
  localparam logic [4:0] CYC_REG_REG  = 5'd4;
  localparam logic [4:0] CYC_MEM_HL   = 5'd7;
  localparam logic [4:0] CYC_REG_IMM  = 5'd7;
  localparam logic [4:0] CYC_HL_IMM   = 5'd10;
  localparam logic [4:0] CYC_ABS      = 5'd13;
  localparam logic [4:0] CYC_SPECIAL  = 5'd9;
  localparam logic [4:0] CYC_INDEXED  = 5'd19;
  localparam logic [4:0] CYC_HALF_IMM = 5'd13;
  localparam logic [4:0] CYC_HALF_REG = 5'd10;

  // Result queue depth (at least two: a store pushes two results)
  localparam int unsigned OUTQ_DEPTH = 4;

  // One result item
  typedef struct packed {
    kind_t       kind;
    logic [15:0] mem_address;
    logic [7:0]  write_data;
    logic [4:0]  cycle_count;
    logic [2:0]  length;
    logic [7:0]  acc_value;
    logic [7:0]  flag_bits;
    logic        last;
  } result_t;

  // Architectural state as seen by the decoder
  typedef struct packed {
    logic [7:0][7:0] regs;
    logic [15:0]     ix;
    logic [15:0]     iy;
    logic [7:0]      vec;
    logic [7:0]      refr;
    logic            pending;
    logic [2:0]      pend_dest;
    logic [4:0]      pend_cycles;
    logic [2:0]      pend_len;
  } arch_t;

  // State update produced for one accepted item
  typedef struct packed {
    logic        main_we;
    logic [2:0]  main_sel;
    logic [7:0]  main_data;
    logic        flag_we;
    logic [7:0]  flag_data;
    logic        idx_we;
    logic        idx_sel_y;
    logic [15:0] idx_data;
    logic        vec_we;
    logic        refr_we;
    logic [2:0]  pc_add;
    logic        rd_start;
    logic        rd_end;
    logic [2:0]  pend_dest;
    logic [4:0]  pend_cycles;
    logic [2:0]  pend_len;
  } update_t;

endpackage

`default_nettype wire

// ----- rtl/cpu_8bit_load_execute.sv -----
// Top level of the 8-bit load-group executor: configuration register,
// decoder, architectural state and result queue. Uses cle_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries either four opcode bytes of a
//   new instruction (in_func = 0) or the byte that answers a pending memory
//   read (in_func = 1). Result channel (out_valid/out_ready) carries read
//   requests, writes, done items and unknown-opcode items.
//   A memory load gives one read request; the following reply item gives the
//   done item. A store gives a write item and then a done item.
//   Throughput: one item per cycle while in_ready is high; decode and state
//   update finish in the accept cycle, so the next item sees the updated
//   registers. Stores give two results, which leave the output one by one.
//   The result queue holds OUTQ_DEPTH items; in_ready stays high while it has
//   room for two, so a stalled receiver backs the input up at one free slot.
//   Reset clears all registers, the pending read and the queue.
//   APB: iff2_r, read at any address, written at 0-3; pready always high.
`default_nettype none

module cpu_8bit_load_execute #(
  parameter int unsigned OUTQ_DEPTH = cle_pkg::OUTQ_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_func,
  input  wire logic [7:0]  in_op_byte0,
  input  wire logic [7:0]  in_op_byte1,
  input  wire logic [7:0]  in_op_byte2,
  input  wire logic [7:0]  in_op_byte3,
  input  wire logic [7:0]  in_read_data,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [15:0]      out_mem_address,
  output logic [7:0]       out_write_data,
  output logic [4:0]       out_cycle_count,
  output logic [2:0]       out_length,
  output logic [7:0]       out_acc_value,
  output logic [7:0]       out_flag_bits,
  output logic             out_last,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic             iff2_r;
  logic             in_fire;
  logic             room2;
  logic [1:0]       res_cnt;
  logic [1:0]       push_cnt;
  cle_pkg::arch_t   st;
  cle_pkg::update_t upd;
  cle_pkg::result_t res0;
  cle_pkg::result_t res1;
  cle_pkg::result_t out_res;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = {31'd0, iff2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iff2_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      iff2_r <= pwdata[0];
    end
  end

  // Accept when the queue has room for a store's two results
  assign in_ready = room2;
  assign in_fire  = in_valid && in_ready;
  assign push_cnt = in_fire ? res_cnt : 2'd0;

  cle_decode u_decode (
    .func    (in_func),
    .b0      (in_op_byte0),
    .b1      (in_op_byte1),
    .b2      (in_op_byte2),
    .b3      (in_op_byte3),
    .rd_data (in_read_data),
    .iff2    (iff2_r),
    .st      (st),
    .upd     (upd),
    .res_cnt (res_cnt),
    .res0    (res0),
    .res1    (res1)
  );

  cle_state u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (in_fire),
    .upd    (upd),
    .st     (st)
  );

  cle_outq #(
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (res0),
    .push1     (res1),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // Unpack the head result onto the ports
  assign out_kind        = out_res.kind;
  assign out_mem_address = out_res.mem_address;
  assign out_write_data  = out_res.write_data;
  assign out_cycle_count = out_res.cycle_count;
  assign out_length      = out_res.length;
  assign out_acc_value   = out_res.acc_value;
  assign out_flag_bits   = out_res.flag_bits;
  assign out_last        = out_res.last;

endmodule

`default_nettype wire

// ----- rtl/cle_decode.sv -----
// Instruction and reply decoder: turns one input item and the current state
// into a state update and up to two result items. Uses cle_pkg.
`default_nettype none

module cle_decode (
  input  wire logic            func,
  input  wire logic [7:0]      b0,
  input  wire logic [7:0]      b1,
  input  wire logic [7:0]      b2,
  input  wire logic [7:0]      b3,
  input  wire logic [7:0]      rd_data,
  input  wire logic            iff2,
  input  wire cle_pkg::arch_t  st,
  output cle_pkg::update_t     upd,
  output logic [1:0]           res_cnt,
  output cle_pkg::result_t     res0,
  output cle_pkg::result_t     res1
);

  typedef enum logic [4:0] {
    ACT_NONE    = 5'b00001,
    ACT_READ    = 5'b00010,
    ACT_WRITE   = 5'b00100,
    ACT_DONE    = 5'b01000,
    ACT_UNKNOWN = 5'b10000
  } act_t;

  act_t        act;
  logic        act_reply;
  logic [15:0] addr;
  logic [7:0]  wdata;
  logic [4:0]  cyc;
  logic [2:0]  len;
  logic [2:0]  dest;
  logic [15:0] hl;
  logic [15:0] xv;
  logic [15:0] xaddr;
  logic [7:0]  spec_v;
  logic [7:0]  half_v;
  logic [7:0]  acc_post;
  logic [7:0]  flg_post;

  assign hl    = {st.regs[cle_pkg::REG_H], st.regs[cle_pkg::REG_L]};
  assign xv    = (b0 == cle_pkg::OP_PFX_FD) ? st.iy : st.ix;
  assign xaddr = xv + {{8{b2[7]}}, b2};
  assign half_v = b1[0] ? xv[7:0] : xv[15:8];

  // Decode the item into an action and its state changes
  always_comb begin
    upd       = '0;
    act       = ACT_NONE;
    act_reply = 1'b0;
    addr      = '0;
    wdata     = '0;
    cyc       = '0;
    len       = '0;
    dest      = '0;
    spec_v    = '0;
    if (func == cle_pkg::FUNC_REPLY) begin
      if (st.pending) begin
        upd.main_we   = 1'b1;
        upd.main_sel  = st.pend_dest;
        upd.main_data = rd_data;
        upd.rd_end    = 1'b1;
        act           = ACT_DONE;
        act_reply     = 1'b1;
        cyc           = st.pend_cycles;
        len           = st.pend_len;
      end
    end else if (!st.pending) begin
      if (b0[7:6] == 2'b01) begin
        // Register to register, and loads and stores through (HL)
        if (b0 == cle_pkg::OP_HALT) begin
          act = ACT_UNKNOWN;
        end else if (b0[2:0] == cle_pkg::OPND_MEM) begin
          act  = ACT_READ;
          addr = hl;
          dest = b0[5:3];
          cyc  = cle_pkg::CYC_MEM_HL;
          len  = 3'd1;
        end else if (b0[5:3] == cle_pkg::OPND_MEM) begin
          act   = ACT_WRITE;
          addr  = hl;
          wdata = st.regs[b0[2:0]];
          cyc   = cle_pkg::CYC_MEM_HL;
          len   = 3'd1;
        end else begin
          upd.main_we   = 1'b1;
          upd.main_sel  = b0[5:3];
          upd.main_data = st.regs[b0[2:0]];
          act           = ACT_DONE;
          cyc           = cle_pkg::CYC_REG_REG;
          len           = 3'd1;
        end
      end else if (b0[7:6] == 2'b00 && b0[2:0] == cle_pkg::OPND_MEM) begin
        // Immediate loads
        if (b0[5:3] == cle_pkg::OPND_MEM) begin
          act   = ACT_WRITE;
          addr  = hl;
          wdata = b1;
          cyc   = cle_pkg::CYC_HL_IMM;
          len   = 3'd2;
        end else begin
          upd.main_we   = 1'b1;
          upd.main_sel  = b0[5:3];
          upd.main_data = b1;
          act           = ACT_DONE;
          cyc           = cle_pkg::CYC_REG_IMM;
          len           = 3'd2;
        end
      end else begin
        case (b0)
          cle_pkg::OP_LD_A_BC: begin
            act  = ACT_READ;
            addr = {st.regs[cle_pkg::REG_B], st.regs[cle_pkg::REG_C]};
            dest = cle_pkg::REG_A;
            cyc  = cle_pkg::CYC_MEM_HL;
            len  = 3'd1;
          end
          cle_pkg::OP_LD_A_DE: begin
            act  = ACT_READ;
            addr = {st.regs[cle_pkg::REG_D], st.regs[cle_pkg::REG_E]};
            dest = cle_pkg::REG_A;
            cyc  = cle_pkg::CYC_MEM_HL;
            len  = 3'd1;
          end
          cle_pkg::OP_LD_BC_A: begin
            act   = ACT_WRITE;
            addr  = {st.regs[cle_pkg::REG_B], st.regs[cle_pkg::REG_C]};
            wdata = st.regs[cle_pkg::REG_A];
            cyc   = cle_pkg::CYC_MEM_HL;
            len   = 3'd1;
          end
          cle_pkg::OP_LD_DE_A: begin
            act   = ACT_WRITE;
            addr  = {st.regs[cle_pkg::REG_D], st.regs[cle_pkg::REG_E]};
            wdata = st.regs[cle_pkg::REG_A];
            cyc   = cle_pkg::CYC_MEM_HL;
            len   = 3'd1;
          end
          cle_pkg::OP_LD_A_NN: begin
            act  = ACT_READ;
            addr = {b2, b1};
            dest = cle_pkg::REG_A;
            cyc  = cle_pkg::CYC_ABS;
            len  = 3'd3;
          end
          cle_pkg::OP_LD_NN_A: begin
            act   = ACT_WRITE;
            addr  = {b2, b1};
            wdata = st.regs[cle_pkg::REG_A];
            cyc   = cle_pkg::CYC_ABS;
            len   = 3'd3;
          end
          cle_pkg::OP_PFX_ED: begin
            cyc = cle_pkg::CYC_SPECIAL;
            len = 3'd2;
            act = ACT_DONE;
            case (b1)
              cle_pkg::ED_LD_A_I: begin
                spec_v        = st.vec;
                upd.main_we   = 1'b1;
                upd.flag_we   = 1'b1;
              end
              cle_pkg::ED_LD_A_R: begin
                spec_v        = st.refr;
                upd.main_we   = 1'b1;
                upd.flag_we   = 1'b1;
              end
              cle_pkg::ED_LD_I_A: upd.vec_we  = 1'b1;
              cle_pkg::ED_LD_R_A: upd.refr_we = 1'b1;
              default: begin
                act = ACT_UNKNOWN;
                cyc = '0;
                len = '0;
              end
            endcase
            // LD A,I and LD A,R: load A, set S Z PV, clear H N
            upd.main_sel  = cle_pkg::REG_A;
            upd.main_data = spec_v;
            upd.flag_data = (st.regs[cle_pkg::REG_F] & ~cle_pkg::FLAG_SPECIAL_MASK) |
                            {spec_v[7], (spec_v == 8'd0), 3'b000, iff2, 2'b00};
          end
          cle_pkg::OP_PFX_DD, cle_pkg::OP_PFX_FD: begin
            upd.idx_sel_y = (b0 == cle_pkg::OP_PFX_FD);
            if (b1[7:6] == 2'b01 && b1[2:0] == cle_pkg::OPND_MEM &&
                b1 != cle_pkg::OP_HALT) begin
              act  = ACT_READ;
              addr = xaddr;
              dest = b1[5:3];
              cyc  = cle_pkg::CYC_INDEXED;
              len  = 3'd3;
            end else if (b1[7:3] == 5'b01110 && b1 != cle_pkg::OP_HALT) begin
              act   = ACT_WRITE;
              addr  = xaddr;
              wdata = st.regs[b1[2:0]];
              cyc   = cle_pkg::CYC_INDEXED;
              len   = 3'd3;
            end else if (b1 == cle_pkg::IX_LD_MEM_N) begin
              act   = ACT_WRITE;
              addr  = xaddr;
              wdata = b3;
              cyc   = cle_pkg::CYC_INDEXED;
              len   = 3'd4;
            end else if (b1 == cle_pkg::IX_LD_LO_N) begin
              upd.idx_we   = 1'b1;
              upd.idx_data = {xv[15:8], b2};
              act          = ACT_DONE;
              cyc          = cle_pkg::CYC_HALF_IMM;
              len          = 3'd3;
            end else if (b1 == cle_pkg::IX_LD_HI_N) begin
              upd.idx_we   = 1'b1;
              upd.idx_data = {b2, xv[7:0]};
              act          = ACT_DONE;
              cyc          = cle_pkg::CYC_HALF_IMM;
              len          = 3'd3;
            end else if (b1[7:6] == 2'b01 && b1[2:1] == 2'b10 &&
                         b1[5:3] != cle_pkg::OPND_MEM) begin
              // Half-register source; H and L destinations name the halves
              act = ACT_DONE;
              cyc = cle_pkg::CYC_HALF_REG;
              len = 3'd2;
              if (b1[5:3] == cle_pkg::REG_H) begin
                upd.idx_we   = 1'b1;
                upd.idx_data = {half_v, xv[7:0]};
              end else if (b1[5:3] == cle_pkg::REG_L) begin
                upd.idx_we   = 1'b1;
                upd.idx_data = {xv[15:8], half_v};
              end else begin
                upd.main_we   = 1'b1;
                upd.main_sel  = b1[5:3];
                upd.main_data = half_v;
              end
            end else begin
              act = ACT_UNKNOWN;
            end
          end
          default: act = ACT_UNKNOWN;
        endcase
      end
    end

    // Advance the program counter and arm the pending read
    if (!act_reply && (act == ACT_READ || act == ACT_WRITE || act == ACT_DONE)) begin
      upd.pc_add = len;
    end
    if (act == ACT_READ) begin
      upd.rd_start    = 1'b1;
      upd.pend_dest   = dest;
      upd.pend_cycles = cyc;
      upd.pend_len    = len;
    end
  end

  // Accumulator and flags as they stand after the update
  always_comb begin
    acc_post = st.regs[cle_pkg::REG_A];
    flg_post = st.regs[cle_pkg::REG_F];
    if (upd.main_we && upd.main_sel == cle_pkg::REG_A) begin
      acc_post = upd.main_data;
    end
    if (upd.main_we && upd.main_sel == cle_pkg::REG_F) begin
      flg_post = upd.main_data;
    end
    if (upd.flag_we) begin
      flg_post = upd.flag_data;
    end
  end

  // Build the result items
  always_comb begin
    res_cnt = 2'd0;
    res0    = '0;
    res1    = '0;
    res0.acc_value = acc_post;
    res0.flag_bits = flg_post;
    res1.acc_value = acc_post;
    res1.flag_bits = flg_post;
    res0.last      = 1'b1;
    res1.last      = 1'b1;
    case (act)
      ACT_READ: begin
        res_cnt          = 2'd1;
        res0.kind        = cle_pkg::KIND_READ;
        res0.mem_address = addr;
      end
      ACT_WRITE: begin
        res_cnt          = 2'd2;
        res0.kind        = cle_pkg::KIND_WRITE;
        res0.mem_address = addr;
        res0.write_data  = wdata;
        res0.last        = 1'b0;
        res1.kind        = cle_pkg::KIND_DONE;
        res1.cycle_count = cyc;
        res1.length      = len;
      end
      ACT_DONE: begin
        res_cnt          = 2'd1;
        res0.kind        = cle_pkg::KIND_DONE;
        res0.cycle_count = cyc;
        res0.length      = len;
      end
      ACT_UNKNOWN: begin
        res_cnt   = 2'd1;
        res0.kind = cle_pkg::KIND_UNKNOWN;
      end
      default: res_cnt = 2'd0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/cle_state.sv -----
// Architectural registers: main file, index registers, I, R, program counter
// and the pending-read record. Applies the decoder's update. Uses cle_pkg.
`default_nettype none

module cle_state (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             upd_en,
  input  wire cle_pkg::update_t upd,
  output cle_pkg::arch_t        st
);

  logic [7:0][7:0] regs_r;
  logic [15:0]     ix_r;
  logic [15:0]     iy_r;
  logic [7:0]      vec_r;
  logic [7:0]      refr_r;
  logic [15:0]     pc_r;
  logic            pending_r;
  logic [2:0]      pend_dest_r;
  logic [4:0]      pend_cycles_r;
  logic [2:0]      pend_len_r;

  // Apply the update of an accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r        <= '0;
      ix_r          <= '0;
      iy_r          <= '0;
      vec_r         <= '0;
      refr_r        <= '0;
      pc_r          <= '0;
      pending_r     <= 1'b0;
      pend_dest_r   <= '0;
      pend_cycles_r <= '0;
      pend_len_r    <= '0;
    end else if (upd_en) begin
      if (upd.main_we) begin
        regs_r[upd.main_sel] <= upd.main_data;
      end
      if (upd.flag_we) begin
        regs_r[cle_pkg::REG_F] <= upd.flag_data;
      end
      if (upd.idx_we && !upd.idx_sel_y) begin
        ix_r <= upd.idx_data;
      end
      if (upd.idx_we && upd.idx_sel_y) begin
        iy_r <= upd.idx_data;
      end
      if (upd.vec_we) begin
        vec_r <= regs_r[cle_pkg::REG_A];
      end
      if (upd.refr_we) begin
        refr_r <= regs_r[cle_pkg::REG_A];
      end
      pc_r <= pc_r + {13'd0, upd.pc_add};
      if (upd.rd_start) begin
        pending_r     <= 1'b1;
        pend_dest_r   <= upd.pend_dest;
        pend_cycles_r <= upd.pend_cycles;
        pend_len_r    <= upd.pend_len;
      end else if (upd.rd_end) begin
        pending_r <= 1'b0;
      end
    end
  end

  assign st.regs        = regs_r;
  assign st.ix          = ix_r;
  assign st.iy          = iy_r;
  assign st.vec         = vec_r;
  assign st.refr        = refr_r;
  assign st.pending     = pending_r;
  assign st.pend_dest   = pend_dest_r;
  assign st.pend_cycles = pend_cycles_r;
  assign st.pend_len    = pend_len_r;

endmodule

`default_nettype wire

// ----- rtl/cle_outq.sv -----
// Result queue: takes zero, one or two result items per cycle and hands out
// one per cycle on its valid/ready port as out_ready allows. Uses cle_pkg.
`default_nettype none

module cle_outq #(
  parameter int unsigned DEPTH = cle_pkg::OUTQ_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [1:0]       push_cnt,
  input  wire cle_pkg::result_t push0,
  input  wire cle_pkg::result_t push1,
  output logic                  room2,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output cle_pkg::result_t      out_res
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cle_pkg::result_t mem_r [DEPTH];
  logic [PW-1:0]    wptr_r;
  logic [PW-1:0]    wptr1;
  logic [PW-1:0]    wptr_nxt;
  logic [PW-1:0]    rptr_r;
  logic [PW-1:0]    rptr_nxt;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic             pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rptr_r];
  assign room2     = (count_r <= CW'(DEPTH - 2));
  assign wptr1     = ptr_inc(wptr_r);

  // Advance pointers and occupancy
  always_comb begin
    wptr_nxt = wptr_r;
    case (push_cnt)
      2'd1:    wptr_nxt = wptr1;
      2'd2:    wptr_nxt = ptr_inc(wptr1);
      default: wptr_nxt = wptr_r;
    endcase
    rptr_nxt  = pop ? ptr_inc(rptr_r) : rptr_r;
    count_nxt = count_r + CW'(push_cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Store the pushed items
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wptr1] <= push1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cle_checker.sv -----
// Port-level checker for the load-group executor, bound to the top level.
// Uses cle_pkg for the result kind codes.
`default_nettype none

module cle_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_kind,
  input wire logic [4:0]  out_cycle_count,
  input wire logic [2:0]  out_length,
  input wire logic        out_last
);

  // Hold a stalled result item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_last))
    else $error("result item changed while stalled");

  // A write item is never marked last: its done item follows it
  a_write_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == cle_pkg::KIND_WRITE |-> !out_last)
    else $error("write item marked last");

  // Unknown opcodes report no time and no length
  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == cle_pkg::KIND_UNKNOWN |->
      out_last && out_cycle_count == 5'd0 && out_length == 3'd0)
    else $error("unknown item with nonzero count");

  // Done items carry a real length and T-state count
  a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == cle_pkg::KIND_DONE |->
      out_last && out_length != 3'd0 && out_length <= 3'd4 && out_cycle_count >= 5'd4)
    else $error("done item with bad length or count");

endmodule

bind cpu_8bit_load_execute cle_checker u_cle_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_kind        (out_kind),
  .out_cycle_count (out_cycle_count),
  .out_length      (out_length),
  .out_last        (out_last)
);

`default_nettype wire
